>>> src/message_header_validator_macros.svh
// assertion macros for the message header validator
`ifndef MESSAGE_HEADER_VALIDATOR_MACROS_SVH
`define MESSAGE_HEADER_VALIDATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked at every rising clk edge outside reset
`define MHV_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// checked at every rising clk edge, reset included
`define MHV_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define MHV_ASSERT(label, prop, msg)
`define MHV_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

>>> src/mhv_pkg.sv
// shared types, constants and command table for the message header validator
`default_nettype none

package mhv_pkg;

	localparam int CMD_BYTES  = 12;
	localparam int CMD_COUNT  = 16;
	localparam int CFG_ADDR_W = 5;

	// header record size and the reciprocal used to divide by it
	localparam int HDR_REC_BYTES  = 88;
	localparam int HDR_DIV_SHIFT  = 40;
	localparam int HDR_DIV_W      = HDR_DIV_SHIFT + 1;
	localparam int HDR_PROD_W     = 32 + HDR_DIV_W;
	localparam int HDR_QUOT_W     = HDR_PROD_W - HDR_DIV_SHIFT;
	localparam logic [HDR_DIV_W-1:0] HDR_DIV_MUL = HDR_DIV_W'(
		((64'd1 << HDR_DIV_SHIFT) + 64'(HDR_REC_BYTES) - 64'd1) / 64'(HDR_REC_BYTES));

	typedef enum logic [1:0] {
		REASON_OK      = 2'd0,
		REASON_MSG_CAP = 2'd1,
		REASON_UNKNOWN = 2'd2,
		REASON_LENGTH  = 2'd3
	} reason_t;

	typedef enum logic [4:0] {
		CMD_VERSION    = 5'd0,
		CMD_VERACK     = 5'd1,
		CMD_PING       = 5'd2,
		CMD_PONG       = 5'd3,
		CMD_INVB       = 5'd4,
		CMD_GETB       = 5'd5,
		CMD_GETBI      = 5'd6,
		CMD_BLOCK      = 5'd7,
		CMD_INVTX      = 5'd8,
		CMD_GETTX      = 5'd9,
		CMD_TX         = 5'd10,
		CMD_GETADDR    = 5'd11,
		CMD_ADDR       = 5'd12,
		CMD_GETHEADERS = 5'd13,
		CMD_HEADERS    = 5'd14,
		CMD_FEEFILTER  = 5'd15,
		CMD_UNKNOWN    = 5'd16
	} cmd_idx_t;

	typedef enum logic [2:0] {
		REG_MAX_MESSAGE  = 3'd0,
		REG_MAX_BLOCK    = 3'd1,
		REG_MAX_TX       = 3'd2,
		REG_MAX_ADDR     = 3'd3,
		REG_MAX_LOCATOR  = 3'd4,
		REG_MAX_HEADERS  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [31:0] max_message_bytes;
		logic [31:0] max_block_bytes;
		logic [31:0] max_transaction_bytes;
		logic [29:0] max_address_entries;
		logic [7:0]  max_locator_entries;
		logic [15:0] max_header_records;
	} mhv_cfg_t;

	// turn a right-justified string literal into bytes with the first char in byte 0
	function automatic logic [8*CMD_BYTES-1:0] pack_word(input logic [8*CMD_BYTES-1:0] s);
		int len;
		logic [8*CMD_BYTES-1:0] w;
		len = 0;
		w = '0;
		for (int i = 0; i < CMD_BYTES; i++) begin
			if (s[8*i +: 8] != 8'h00) begin
				len++;
			end
		end
		for (int i = 0; i < CMD_BYTES; i++) begin
			if (i < len) begin
				w[8*i +: 8] = s[8*(len-1-i) +: 8];
			end
		end
		return w;
	endfunction

	localparam logic [8*CMD_BYTES-1:0] CMD_WORDS [CMD_COUNT] = '{
		pack_word("version"), pack_word("verack"), pack_word("ping"), pack_word("pong"),
		pack_word("invb"), pack_word("getb"), pack_word("getbi"), pack_word("block"),
		pack_word("invtx"), pack_word("gettx"), pack_word("tx"),
		pack_word("getaddr"), pack_word("addr"),
		pack_word("getheaders"), pack_word("headers"), pack_word("feefilter")
	};

endpackage

`default_nettype wire

>>> src/mhv_cfg_regs.sv
// configuration register bank with apb-style access
`default_nettype none

module mhv_cfg_regs
	import mhv_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	output mhv_cfg_t                   cfg
);

	mhv_cfg_t cfg_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_message_bytes     <= 32'd2097152;
			cfg_q.max_block_bytes       <= 32'd1048576;
			cfg_q.max_transaction_bytes <= 32'd1048576;
			cfg_q.max_address_entries   <= 30'd1000;
			cfg_q.max_locator_entries   <= 8'd32;
			cfg_q.max_header_records    <= 16'd2000;
		end else if (wr_en) begin
			case (reg_idx)
				REG_MAX_MESSAGE: begin
					cfg_q.max_message_bytes <= pwdata;
				end
				REG_MAX_BLOCK: begin
					cfg_q.max_block_bytes <= pwdata;
				end
				REG_MAX_TX: begin
					cfg_q.max_transaction_bytes <= pwdata;
				end
				REG_MAX_ADDR: begin
					cfg_q.max_address_entries <= pwdata[29:0];
				end
				REG_MAX_LOCATOR: begin
					cfg_q.max_locator_entries <= pwdata[7:0];
				end
				REG_MAX_HEADERS: begin
					cfg_q.max_header_records <= pwdata[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAX_MESSAGE: prdata = cfg_q.max_message_bytes;
			REG_MAX_BLOCK:   prdata = cfg_q.max_block_bytes;
			REG_MAX_TX:      prdata = cfg_q.max_transaction_bytes;
			REG_MAX_ADDR:    prdata = {2'b00, cfg_q.max_address_entries};
			REG_MAX_LOCATOR: prdata = {24'd0, cfg_q.max_locator_entries};
			REG_MAX_HEADERS: prdata = {16'd0, cfg_q.max_header_records};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

>>> src/mhv_cmd_match.sv
// command word normalize and allowlist match
`default_nettype none

module mhv_cmd_match
	import mhv_pkg::*;
(
	input  wire logic [63:0] command_head,
	input  wire logic [31:0] command_tail,
	output cmd_idx_t         cmd_idx
);

	logic [8*CMD_BYTES-1:0] raw;
	logic [8*CMD_BYTES-1:0] name;
	logic [CMD_COUNT-1:0]   hit;

	assign raw = {command_tail, command_head};

	// cut at first nul, fold A..Z to a..z
	always_comb begin
		logic       ended;
		logic [7:0] b;
		ended = 1'b0;
		name  = '0;
		for (int i = 0; i < CMD_BYTES; i++) begin
			b = raw[8*i +: 8];
			if (b == 8'h00) begin
				ended = 1'b1;
			end
			if (ended) begin
				b = 8'h00;
			end else if (b >= 8'h41 && b <= 8'h5A) begin
				b = b + 8'h20;
			end
			name[8*i +: 8] = b;
		end
	end

	always_comb begin
		for (int j = 0; j < CMD_COUNT; j++) begin
			hit[j] = (name == CMD_WORDS[j]);
		end
	end

	always_comb begin
		cmd_idx = CMD_UNKNOWN;
		for (int j = CMD_COUNT - 1; j >= 0; j--) begin
			if (hit[j]) begin
				cmd_idx = cmd_idx_t'(5'(j));
			end
		end
	end

endmodule

`default_nettype wire

>>> src/mhv_len_check.sv
// per-command payload length rules and reason priority
`default_nettype none

module mhv_len_check
	import mhv_pkg::*;
(
	input  wire cmd_idx_t    cmd_idx,
	input  wire logic [31:0] payload_length,
	input  wire mhv_cfg_t    cfg,
	output reason_t          reason
);

	logic [31:0]            gh_off;
	logic                   gh_ok;
	logic [31:0]            hd_off;
	logic [HDR_PROD_W-1:0]  hd_prod;
	logic [HDR_QUOT_W-1:0]  hd_quot;
	logic                   hd_exact;
	logic                   hd_ok;
	logic                   addr_ok;
	logic                   fits;

	// locator list: 33 + 32 * k
	assign gh_off = payload_length - 32'd33;
	assign gh_ok  = (payload_length >= 32'd33) && (gh_off[4:0] == 5'd0) &&
		(gh_off[31:5] <= {19'd0, cfg.max_locator_entries});

	// header records: 2 + rec * k, quotient and exactness from one reciprocal product
	assign hd_off   = payload_length - 32'd2;
	assign hd_prod  = {{HDR_DIV_W{1'b0}}, hd_off} * {32'd0, HDR_DIV_MUL};
	assign hd_quot  = hd_prod[HDR_PROD_W-1:HDR_DIV_SHIFT];
	assign hd_exact = {1'b0, hd_prod[HDR_DIV_SHIFT-1:0]} < HDR_DIV_MUL;
	assign hd_ok    = (payload_length >= 32'd2) && hd_exact &&
		(hd_quot != '0) && (hd_quot <= HDR_QUOT_W'(cfg.max_header_records));

	assign addr_ok = (payload_length[1:0] == 2'b00) &&
		(payload_length <= {cfg.max_address_entries, 2'b00});

	always_comb begin
		case (cmd_idx)
			CMD_VERSION:    fits = payload_length <= 32'd24;
			CMD_VERACK,
			CMD_PING,
			CMD_PONG,
			CMD_GETADDR:    fits = payload_length == 32'd0;
			CMD_INVB,
			CMD_GETB,
			CMD_INVTX,
			CMD_GETTX:      fits = payload_length == 32'd32;
			CMD_GETBI,
			CMD_FEEFILTER:  fits = payload_length == 32'd8;
			CMD_BLOCK:      fits = (payload_length != 32'd0) &&
				(payload_length <= cfg.max_block_bytes);
			CMD_TX:         fits = (payload_length != 32'd0) &&
				(payload_length <= cfg.max_transaction_bytes);
			CMD_ADDR:       fits = addr_ok;
			CMD_GETHEADERS: fits = gh_ok;
			CMD_HEADERS:    fits = hd_ok;
			default:        fits = 1'b0;
		endcase
	end

	always_comb begin
		if (payload_length > cfg.max_message_bytes) begin
			reason = REASON_MSG_CAP;
		end else if (cmd_idx == CMD_UNKNOWN) begin
			reason = REASON_UNKNOWN;
		end else if (!fits) begin
			reason = REASON_LENGTH;
		end else begin
			reason = REASON_OK;
		end
	end

endmodule

`default_nettype wire

>>> src/message_header_validator.sv
// top level of the message header validator: input register, checks, result register
// the accepted item is registered in stage 1, then its result in the result register
// throughput: one item per cycle while out_ready holds; the path from the input register
// through the command match and length rules to the result register sets the clock
// reset: arst_n clears both stage valids and loads the register defaults at once
// a stalled result holds in the result register; stage 1 takes one more item and then holds
`default_nettype none
`include "message_header_validator_macros.svh"

module message_header_validator
	import mhv_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration port
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [CFG_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	// input channel
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [63:0]           command_head,
	input  wire logic [31:0]           command_tail,
	input  wire logic [31:0]           payload_length,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       accepted,
	output logic      [4:0]            command_index,
	output logic      [1:0]            reject_reason
);

	mhv_cfg_t    cfg;

	// stage 1: registered input item
	logic        valid_s1;
	logic [63:0] head_s1;
	logic [31:0] tail_s1;
	logic [31:0] len_s1;

	// stage 2: registered result item
	logic        valid_s2;
	logic        accepted_s2;
	cmd_idx_t    idx_s2;
	reason_t     reason_s2;

	cmd_idx_t    cmd_idx;
	reason_t     reason;
	logic        adv_s1;
	logic        load_s1;

	// stage 1 moves on whenever the result register is free or being drained
	assign adv_s1   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s1;
	assign load_s1  = in_valid && in_ready;

	mhv_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// command normalize and table lookup
	mhv_cmd_match u_match (
		.command_head (head_s1),
		.command_tail (tail_s1),
		.cmd_idx      (cmd_idx)
	);

	// message cap, unknown command and per-command length rule
	mhv_len_check u_len (
		.cmd_idx        (cmd_idx),
		.payload_length (len_s1),
		.cfg            (cfg),
		.reason         (reason)
	);

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv_s1) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (load_s1) begin
			head_s1 <= command_head;
			tail_s1 <= command_tail;
			len_s1  <= payload_length;
		end
		if (adv_s1 && valid_s1) begin
			accepted_s2 <= (reason == REASON_OK);
			idx_s2      <= cmd_idx;
			reason_s2   <= reason;
		end
	end

	assign out_valid     = valid_s2;
	assign accepted      = accepted_s2;
	assign command_index = idx_s2;
	assign reject_reason = reason_s2;

	// accept flag agrees with the reason code
	`MHV_ASSERT(a_accept_reason, out_valid |-> (accepted == (reject_reason == REASON_OK)), "accepted disagrees with reject_reason")
	// unknown reason only for an unknown index, unknown index never passes the word check
	`MHV_ASSERT(a_unknown_idx, out_valid && (reject_reason == REASON_UNKNOWN) |-> (command_index == CMD_UNKNOWN), "unknown reason with a known index")
	`MHV_ASSERT(a_unknown_not_ok, out_valid && (command_index == CMD_UNKNOWN) |-> (reject_reason == REASON_MSG_CAP || reject_reason == REASON_UNKNOWN), "unknown index not rejected")
	// an item in stage 1 reaches the result register when it advances
	`MHV_ASSERT(a_s1_to_s2, valid_s1 && adv_s1 |=> valid_s2, "stage 1 item lost")
	// a waiting result blocks new input only while stage 1 is full
	`MHV_ASSERT_ALWAYS(a_ready_free, !valid_s1 |-> in_ready, "input blocked with empty stage 1")

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench for the message header validator: random and directed headers
module tb
	import mhv_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// one header as driven on the input channel
	typedef struct packed {
		logic [63:0] head;
		logic [31:0] tail;
		logic [31:0] nbytes;
	} msg_header_t;

	// one expected verdict on the result channel
	typedef struct {
		logic     accepted;
		cmd_idx_t idx;
		reason_t  reason;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// configuration port, driven only by the sequencing initial block
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]           pwdata = '0;
	logic [31:0]           prdata;
	logic                  pready;

	// input channel, driven only by the header driver
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [63:0] command_head = '0;
	logic [31:0] command_tail = '0;
	logic [31:0] payload_length = '0;

	// result channel
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       accepted;
	logic [4:0] command_index;
	logic [1:0] reject_reason;

	// headers waiting to be driven and verdicts waiting to come out
	msg_header_t pending_headers[$];
	verdict_t    expected_verdicts[$];

	// our own copy of the limit registers, updated as they are written
	mhv_cfg_t limits;

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  mismatch_count = 0;
	// set at a rising edge when the header on the bus was taken
	bit  header_taken = 1'b0;

	message_header_validator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command_head   (command_head),
		.command_tail   (command_tail),
		.payload_length (payload_length),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.command_index  (command_index),
		.reject_reason  (reject_reason)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	// the lower-case spelling of each allowed command word
	function automatic string spell_command(cmd_idx_t c);
		case (c)
			CMD_VERSION:    return "version";
			CMD_VERACK:     return "verack";
			CMD_PING:       return "ping";
			CMD_PONG:       return "pong";
			CMD_INVB:       return "invb";
			CMD_GETB:       return "getb";
			CMD_GETBI:      return "getbi";
			CMD_BLOCK:      return "block";
			CMD_INVTX:      return "invtx";
			CMD_GETTX:      return "gettx";
			CMD_TX:         return "tx";
			CMD_GETADDR:    return "getaddr";
			CMD_ADDR:       return "addr";
			CMD_GETHEADERS: return "getheaders";
			CMD_HEADERS:    return "headers";
			CMD_FEEFILTER:  return "feefilter";
			default:        return "";
		endcase
	endfunction

	// verdict for one header under the current limits
	function automatic verdict_t judge_header(logic [63:0] head, logic [31:0] tail,
			logic [31:0] nbytes);
		logic [7:0] text [CMD_BYTES];
		logic [7:0] b;
		logic [7:0] want_b;
		bit ended;
		bit same;
		bit fits;
		string w;
		cmd_idx_t hit;
		longint unsigned n;
		longint unsigned k;
		verdict_t v;
		// cut at the first zero byte, fold A..Z to lower case, keep everything else
		ended = 1'b0;
		for (int i = 0; i < CMD_BYTES; i++) begin
			b = (i < 8) ? head[8*i +: 8] : tail[8*(i-8) +: 8];
			if (b == 8'h00) begin
				ended = 1'b1;
			end
			if (ended) begin
				b = 8'h00;
			end else if (b >= "A" && b <= "Z") begin
				b = b + 8'h20;
			end
			text[i] = b;
		end
		hit = CMD_UNKNOWN;
		for (int c = 0; c < CMD_COUNT; c++) begin
			w = spell_command(cmd_idx_t'(c));
			same = 1'b1;
			for (int i = 0; i < CMD_BYTES; i++) begin
				want_b = (i < w.len()) ? w[i] : 8'h00;
				if (text[i] != want_b) begin
					same = 1'b0;
				end
			end
			if (same && hit == CMD_UNKNOWN) begin
				hit = cmd_idx_t'(c);
			end
		end
		// per-command length rules, in 64-bit arithmetic so nothing wraps
		n = nbytes;
		fits = 1'b0;
		case (hit)
			CMD_VERSION: fits = (n <= 24);
			CMD_VERACK, CMD_PING, CMD_PONG, CMD_GETADDR: fits = (n == 0);
			CMD_INVB, CMD_GETB, CMD_INVTX, CMD_GETTX: fits = (n == 32);
			CMD_GETBI, CMD_FEEFILTER: fits = (n == 8);
			CMD_BLOCK: fits = (n != 0) && (n <= limits.max_block_bytes);
			CMD_TX: fits = (n != 0) && (n <= limits.max_transaction_bytes);
			CMD_ADDR: begin
				fits = (n % 4 == 0) && (n <= 64'(limits.max_address_entries) * 4);
			end
			CMD_GETHEADERS: begin
				// one count byte, k locator hashes and the stop hash
				if (n >= 33 && (n - 33) % 32 == 0) begin
					fits = ((n - 33) / 32) <= limits.max_locator_entries;
				end
			end
			CMD_HEADERS: begin
				// two count bytes, then at least one header record
				if (n >= 2 && (n - 2) % HDR_REC_BYTES == 0) begin
					k = (n - 2) / HDR_REC_BYTES;
					fits = (k != 0) && (k <= limits.max_header_records);
				end
			end
			default: fits = 1'b0;
		endcase
		// message cap wins over the word, the word over the length rule
		if (n > limits.max_message_bytes) begin
			v.reason = REASON_MSG_CAP;
		end else if (hit == CMD_UNKNOWN) begin
			v.reason = REASON_UNKNOWN;
		end else if (!fits) begin
			v.reason = REASON_LENGTH;
		end else begin
			v.reason = REASON_OK;
		end
		v.accepted = (v.reason == REASON_OK);
		v.idx = hit;
		return v;
	endfunction

	// lay a word into the 12 command bytes, byte 0 lowest; optional random case and junk
	function automatic logic [8*CMD_BYTES-1:0] pack_command(string w, bit fold, bit junk);
		logic [8*CMD_BYTES-1:0] bytes;
		logic [7:0] b;
		for (int i = 0; i < CMD_BYTES; i++) begin
			if (i < w.len()) begin
				b = w[i];
				if (fold && b >= "a" && b <= "z" && $urandom_range(0, 1) == 1) begin
					b = b - 8'h20;
				end
			end else if (i == w.len()) begin
				b = 8'h00;
			end else begin
				// bytes past the terminator must be ignored, so fill them with noise when junk is set
				b = junk ? 8'($urandom) : 8'h00;
			end
			bytes[8*i +: 8] = b;
		end
		return bytes;
	endfunction

	// a payload length aimed at the rule of one command, its edges and the message cap
	function automatic logic [31:0] pick_length(cmd_idx_t c);
		longint unsigned v;
		int mode;
		bit at_max;
		at_max = ($urandom_range(0, 2) == 0);
		case (c)
			CMD_VERSION: v = $urandom_range(0, 24);
			CMD_VERACK, CMD_PING, CMD_PONG, CMD_GETADDR: v = 0;
			CMD_INVB, CMD_GETB, CMD_INVTX, CMD_GETTX: v = 32;
			CMD_GETBI, CMD_FEEFILTER: v = 8;
			CMD_BLOCK: begin
				v = at_max ? limits.max_block_bytes : $urandom_range(1, limits.max_block_bytes);
			end
			CMD_TX: begin
				v = at_max ? limits.max_transaction_bytes
					: $urandom_range(1, limits.max_transaction_bytes);
			end
			CMD_ADDR: begin
				v = 4 * (at_max ? 64'(limits.max_address_entries)
					: 64'($urandom_range(0, limits.max_address_entries)));
			end
			CMD_GETHEADERS: begin
				v = 33 + 32 * (at_max ? 64'(limits.max_locator_entries)
					: 64'($urandom_range(0, limits.max_locator_entries)));
			end
			CMD_HEADERS: begin
				v = 2 + HDR_REC_BYTES * (at_max ? 64'(limits.max_header_records)
					: 64'($urandom_range(1, limits.max_header_records)));
			end
			default: v = $urandom_range(0, 64);
		endcase
		mode = $urandom_range(0, 99);
		if (mode < 45) begin
			return v[31:0];
		end else if (mode < 70) begin
			// one below, on, or one above the legal value
			v = v + $urandom_range(0, 2) - 1;
			return v[31:0];
		end else if (mode < 80) begin
			return limits.max_message_bytes + $urandom_range(0, 1);
		end else if (mode < 90) begin
			return $urandom_range(0, 400);
		end
		return $urandom;
	endfunction

	// mostly well-formed headers with random case and junk, some garbled commands
	function automatic msg_header_t random_header();
		msg_header_t h;
		logic [8*CMD_BYTES-1:0] bytes;
		cmd_idx_t c;
		string w;
		int pos;
		if ($urandom_range(0, 99) < 80) begin
			c = cmd_idx_t'($urandom_range(0, CMD_COUNT - 1));
			bytes = pack_command(spell_command(c), 1'b1, 1'($urandom_range(0, 1)));
			h.nbytes = pick_length(c);
		end else begin
			w = spell_command(cmd_idx_t'($urandom_range(0, CMD_COUNT - 1)));
			case ($urandom_range(0, 4))
				0: bytes = {$urandom, $urandom, $urandom};
				// empty command: first byte is the terminator
				1: bytes = pack_command("", 1'b0, 1'b1);
				2: begin
					// one byte swapped for any nonzero value, non-ASCII included
					bytes = pack_command(w, 1'b1, 1'b1);
					pos = $urandom_range(0, w.len() - 1);
					bytes[8*pos +: 8] = 8'($urandom_range(1, 255));
				end
				3: bytes = pack_command(w.substr(0, w.len() - 2), 1'b1, 1'b1);
				default: bytes = pack_command({w, "s"}, 1'b1, 1'b1);
			endcase
			h.nbytes = pick_length(cmd_idx_t'($urandom_range(0, CMD_COUNT)));
		end
		h.head = bytes[63:0];
		h.tail = bytes[95:64];
		return h;
	endfunction

	task automatic push_raw(logic [8*CMD_BYTES-1:0] bytes, logic [31:0] nbytes);
		msg_header_t h;
		h.head = bytes[63:0];
		h.tail = bytes[95:64];
		h.nbytes = nbytes;
		pending_headers.push_back(h);
	endtask

	task automatic push_named(string w, logic [31:0] nbytes);
		push_raw(pack_command(w, 1'b0, 1'b0), nbytes);
	endtask

	// write one limit register over the config port: setup cycle, then access cycle
	task automatic write_limit(reg_idx_t r, logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(4 * r);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		// the write lands at the rising edge in between
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (r)
			REG_MAX_MESSAGE: limits.max_message_bytes = value;
			REG_MAX_BLOCK:   limits.max_block_bytes = value;
			REG_MAX_TX:      limits.max_transaction_bytes = value;
			REG_MAX_ADDR:    limits.max_address_entries = value[29:0];
			REG_MAX_LOCATOR: limits.max_locator_entries = value[7:0];
			REG_MAX_HEADERS: limits.max_header_records = value[15:0];
			default: ;
		endcase
	endtask

	task automatic write_all_limits(logic [31:0] msg, logic [31:0] blk, logic [31:0] txn,
			logic [31:0] addr_n, logic [31:0] loc_n, logic [31:0] rec_n);
		write_limit(REG_MAX_MESSAGE, msg);
		write_limit(REG_MAX_BLOCK, blk);
		write_limit(REG_MAX_TX, txn);
		write_limit(REG_MAX_ADDR, addr_n);
		write_limit(REG_MAX_LOCATOR, loc_n);
		write_limit(REG_MAX_HEADERS, rec_n);
	endtask

	// hold until every header is driven and every verdict is back, then let the
	// two pipeline stages settle a little longer; looked at on rising edges, where
	// the driver's last update has already landed
	task automatic wait_for_drain();
		while (pending_headers.size() != 0 || in_valid || expected_verdicts.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	// one stretch of random headers under fixed idle rates; optionally the sender
	// stops halfway until the block has emptied
	task automatic run_phase(int count, int send_pct, int recv_pct, bit pause_midway);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2) begin
				wait_for_drain();
			end
			pending_headers.push_back(random_header());
		end
		wait_for_drain();
	endtask

	// header driver: a new header only once the last one was taken, gaps at random
	always @(negedge clk) begin : drive_headers
		msg_header_t h;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || header_taken) begin
				if (pending_headers.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					h = pending_headers.pop_front();
					in_valid <= 1'b1;
					command_head <= h.head;
					command_tail <= h.tail;
					payload_length <= h.nbytes;
				end else begin
					in_valid <= 1'b0;
				end
			end
			// receiver stalls at its own rate
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// at each rising edge: predict for a taken header, check a delivered verdict
	always @(posedge clk) begin : watch_results
		verdict_t want;
		header_taken = arst_n && in_valid && in_ready;
		if (header_taken) begin
			expected_verdicts.push_back(judge_header(command_head, command_tail,
				payload_length));
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("verdict with no header waiting: accepted %0d command_index %0d reason %0d",
					accepted, command_index, reject_reason);
				mismatch_count++;
			end else begin
				want = expected_verdicts.pop_front();
				if (accepted !== want.accepted) begin
					$error("accepted: expected %0d, got %0d", want.accepted, accepted);
					mismatch_count++;
				end
				if (command_index !== want.idx) begin
					$error("command_index: expected %0d, got %0d", want.idx, command_index);
					mismatch_count++;
				end
				if (reject_reason !== want.reason) begin
					$error("reject_reason: expected %0d, got %0d", want.reason, reject_reason);
					mismatch_count++;
				end
			end
		end
	end

	// main sequence
	initial begin
		logic [8*CMD_BYTES-1:0] bytes;
		// limits after reset
		limits.max_message_bytes = 32'd2097152;
		limits.max_block_bytes = 32'd1048576;
		limits.max_transaction_bytes = 32'd1048576;
		limits.max_address_entries = 30'd1000;
		limits.max_locator_entries = 8'd32;
		limits.max_header_records = 16'd2000;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed headers under the reset limits: every command, rule edges,
		// message cap priority, terminator handling and garbled words
		push_named("version", 0);
		push_named("VERSION", 24);
		push_named("version", 25);
		push_named("verack", 0);
		push_named("Ping", 0);
		push_named("pong", 0);
		push_named("invb", 32);
		push_named("getb", 32);
		push_named("getbi", 8);
		push_named("block", 1);
		push_named("block", 0);
		push_named("invtx", 32);
		push_named("gettx", 32);
		push_named("tx", 1048576);
		push_named("getaddr", 0);
		push_named("addr", 4000);
		push_named("getheaders", 33 + 32 * 32);
		push_named("headers", 2 + HDR_REC_BYTES * 2000);
		// headers with a count but no records
		push_named("headers", 2);
		push_named("feefilter", 8);
		// over the message cap: index still reported
		push_named("ping", 2097153);
		// empty command
		push_raw('0, 0);
		// noise past the terminator is ignored
		push_raw(pack_command("ping", 1'b0, 1'b1), 0);
		// a byte with the top bit set never folds or matches
		bytes = pack_command("ping", 1'b0, 1'b0);
		bytes[15:8] = 8'hC9;
		push_raw(bytes, 0);
		// all ones everywhere: cap first, unknown index
		push_raw('1, 32'hFFFF_FFFF);

		run_phase(150, 31, 83, 1'b0);

		// moderate random limits
		write_all_limits($urandom_range(1 << 12, 1 << 24), $urandom_range(1, 1 << 20),
			$urandom_range(1, 1 << 20), $urandom_range(0, 3000), $urandom_range(0, 255),
			$urandom_range(0, 3000));
		run_phase(175, 31, 83, 1'b0);

		// every limit at zero, and a mid-phase pause of the sender
		write_all_limits(0, 0, 0, 0, 0, 0);
		run_phase(175, 83, 31, 1'b1);

		// every limit at its top, upper bits of the narrow registers dropped
		write_all_limits('1, '1, '1, '1, '1, '1);
		run_phase(175, 83, 31, 1'b0);

		// tight limits near the smallest legal sizes
		write_all_limits(300, 1, 2, 1, 0, 1);
		run_phase(175, 0, 0, 1'b0);

		// full-width random writes
		write_all_limits($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		run_phase(175, 0, 0, 1'b0);

		repeat (5) @(negedge clk);
		if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("tb failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+src
src/mhv_pkg.sv
src/mhv_cfg_regs.sv
src/mhv_cmd_match.sv
src/mhv_len_check.sv
src/message_header_validator.sv
tb/tb.sv
